// ----- sv/rgr_pkg.sv -----
// Shared types and constants of the RadioGatun[32] generator.
// Holds the belt/mill sizes, rotation table, command/status structs and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package rgr_pkg;

    localparam int BELT_LEN     = 39;
    localparam int MILL_LEN     = 19;
    localparam int LANE_LEN     = 13;
    localparam int BLANK_ROUNDS = 17;
    localparam int WARM_DRAWS   = 100;
    localparam int CNT_W        = $clog2(WARM_DRAWS);

    // exact divide by 32767 of the scaled product
    localparam logic [15:0] SCALE_DIV = 16'd32767;
    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_MUL = 16'd52429;

    // running rotation amounts of the gamma step, r = (c + r) mod 32
    localparam logic [4:0] ROT_AMT [MILL_LEN] = '{
        5'd0,  5'd1,  5'd3,  5'd6,  5'd10, 5'd15, 5'd21, 5'd28, 5'd4,  5'd13,
        5'd23, 5'd2,  5'd14, 5'd27, 5'd9,  5'd24, 5'd8,  5'd25, 5'd11
    };

    typedef enum logic [1:0] {
        KIND_RESTART = 2'd0,
        KIND_DRAW    = 2'd1,
        KIND_RANGE   = 2'd2
    } rgr_kind_t;

    typedef enum logic [1:0] {
        RES_SEED  = 2'd0,
        RES_DRAW  = 2'd1,
        RES_RANGE = 2'd2,
        RES_ERROR = 2'd3
    } rgr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIGIT,
        ST_LOAD,
        ST_BLANK,
        ST_WARM,
        ST_DRAW,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } rgr_state_t;

    typedef struct packed {
        logic     capture;     // latch a new input word
        logic     digit_step;  // peel one decimal digit off the seed
        logic     load_text;   // clear belt/mill and inject the seed text
        logic     round;       // unconditional blank round
        logic     draw;        // draw step: round when due, toggle phase
        logic     mul;         // span * draw
        logic     div;         // exact divide by 32767
        logic     finish;      // write the result register
        rgr_sel_t sel;
    } rgr_cmd_t;

    typedef struct packed {
        logic digit_last;
        logic range_bad;
        logic out_free;
    } rgr_stat_t;

endpackage

// ----- sv/rgr_ctrl.sv -----
// Sequencing controller of the RadioGatun[32] generator.
// Steps restart, draw and range-draw words through the datapath. Uses rgr_pkg.
`timescale 1ns / 1ps

module rgr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  rgr_pkg::rgr_stat_t stat,
    output rgr_pkg::rgr_cmd_t  cmd
);
    import rgr_pkg::*;

    rgr_state_t       state_reg, state_next;
    logic [1:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state, kind and loop counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_DRAW;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel    = RES_DRAW;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    kind_next   = kind;
                    if (kind == KIND_RESTART)
                        state_next = ST_DIGIT;
                    else if (kind == KIND_RANGE)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_DRAW;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.range_bad ? ST_FINISH : ST_DRAW;
            end
            ST_DIGIT:
            begin
                cmd.digit_step = 1'b1;
                if (stat.digit_last)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_text = 1'b1;
                cnt_next      = '0;
                state_next    = ST_BLANK;
            end
            ST_BLANK:
            begin
                cmd.round = 1'b1;
                if (cnt_reg == CNT_W'(BLANK_ROUNDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_WARM;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_WARM:
            begin
                cmd.draw = 1'b1;
                if (cnt_reg == CNT_W'(WARM_DRAWS - 1))
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DRAW:
            begin
                cmd.draw   = 1'b1;
                state_next = (kind_reg == KIND_RANGE) ? ST_MUL : ST_FINISH;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (kind_reg == KIND_RESTART)
                    cmd.sel = RES_SEED;
                else if (kind_reg == KIND_RANGE)
                    cmd.sel = stat.range_bad ? RES_ERROR : RES_RANGE;
                else
                    cmd.sel = RES_DRAW;
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/rgr_core.sv -----
// Belt and mill state with the RadioGatun[32] round, plus seed text builder.
// Holds the seed register and the draw phase. Uses rgr_pkg.
`timescale 1ns / 1ps

module rgr_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [15:0]      cfg_write_data,
    input  rgr_pkg::rgr_cmd_t cmd,
    output logic [15:0]      seed,
    output logic [14:0]      draw15,
    output logic             digit_last
);
    import rgr_pkg::*;

    logic [31:0] belt_reg [BELT_LEN];
    logic [31:0] mill_reg [MILL_LEN];
    logic        round_due_reg;
    logic [15:0] seed_reg;
    logic [14:0] draw_reg;

    logic [15:0] work_reg;
    logic [39:0] txt_reg;
    logic [2:0]  ndig_reg;

    logic [31:0] fed     [BELT_LEN];
    logic [31:0] belt_nx [BELT_LEN];
    logic [31:0] saved   [3];
    logic [31:0] gam_in  [MILL_LEN];
    logic [63:0] gam_dbl [MILL_LEN];
    logic [31:0] gam     [MILL_LEN];
    logic [31:0] mill_nx [MILL_LEN];
    logic [31:0] word_sel;

    logic [31:0] dprod;
    logic [12:0] quot;
    logic [15:0] q10;
    logic [15:0] rem16;
    logic [7:0]  text_b [12];
    logic [31:0] text_w [3];
    logic [31:0] belt_ld [BELT_LEN];
    logic [31:0] mill_ld [MILL_LEN];

    assign seed       = seed_reg;
    assign draw15     = draw_reg;

    // one full round: belt feed-forward and rotation, gamma/pi/theta, injection, iota
    always_comb
    begin
        fed = belt_reg;
        for (int c = 0; c < 12; c++)
            fed[c + (c % 3) * LANE_LEN] = fed[c + (c % 3) * LANE_LEN] ^ mill_reg[c + 1];
        for (int l = 0; l < 3; l++)
        begin
            saved[l] = fed[l * LANE_LEN + LANE_LEN - 1];
            belt_nx[l * LANE_LEN] = fed[l * LANE_LEN + LANE_LEN - 1];
            for (int k = 1; k < LANE_LEN; k++)
                belt_nx[l * LANE_LEN + k] = fed[l * LANE_LEN + k - 1];
        end
        for (int c = 0; c < MILL_LEN; c++)
        begin
            gam_in[c]  = mill_reg[(7 * c) % MILL_LEN]
                       ^ (mill_reg[(7 * c + 1) % MILL_LEN] | ~mill_reg[(7 * c + 2) % MILL_LEN]);
            gam_dbl[c] = {gam_in[c], gam_in[c]} >> ROT_AMT[c];
            gam[c]     = gam_dbl[c][31:0];
        end
        for (int c = 0; c < MILL_LEN; c++)
            mill_nx[c] = gam[c] ^ gam[(c + 1) % MILL_LEN] ^ gam[(c + 4) % MILL_LEN];
        for (int l = 0; l < 3; l++)
            mill_nx[LANE_LEN + l] = mill_nx[LANE_LEN + l] ^ saved[l];
        mill_nx[0] = mill_nx[0] ^ 32'h1;
    end

    // drawn word: after a round word 1, else word 2
    assign word_sel = round_due_reg ? mill_nx[1] : mill_reg[2];

    // one decimal digit per step, divide by ten through the reciprocal
    assign dprod      = 32'(work_reg) * 32'(DIV10_MUL);
    assign quot       = dprod[31:19];
    assign q10        = ({3'b000, quot} << 3) + ({3'b000, quot} << 1);
    assign rem16      = work_reg - q10;
    assign digit_last = (quot == 13'd0);

    // seed text: digits most significant first, then the 0x01 terminator;
    // cleared belt and mill with the text block injected
    always_comb
    begin
        for (int i = 0; i < 12; i++)
            text_b[i] = 8'h00;
        for (int i = 0; i < 5; i++)
            text_b[i] = txt_reg[8 * i +: 8];
        for (int i = 0; i < 6; i++)
        begin
            if (ndig_reg == 3'(i))
                text_b[i] = 8'h01;
        end
        for (int w = 0; w < 3; w++)
            text_w[w] = {text_b[4 * w + 3], text_b[4 * w + 2],
                         text_b[4 * w + 1], text_b[4 * w]};
        for (int i = 0; i < BELT_LEN; i++)
            belt_ld[i] = '0;
        for (int i = 0; i < MILL_LEN; i++)
            mill_ld[i] = '0;
        for (int w = 0; w < 3; w++)
        begin
            belt_ld[w * LANE_LEN]     = text_w[w];
            mill_ld[MILL_LEN - 3 + w] = text_w[w];
        end
    end

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_write_en)
            seed_reg <= cfg_write_data;
    end

    // digit working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            work_reg <= seed_reg;
            txt_reg  <= '0;
            ndig_reg <= '0;
        end
        else if (cmd.digit_step)
        begin
            work_reg <= {3'b000, quot};
            txt_reg  <= {txt_reg[31:0], 4'h3, rem16[3:0]};
            ndig_reg <= ndig_reg + 1'b1;
        end
    end

    // belt, mill and draw phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BELT_LEN; i++)
                belt_reg[i] <= '0;
            for (int i = 0; i < MILL_LEN; i++)
                mill_reg[i] <= '0;
            round_due_reg <= 1'b1;
            draw_reg      <= '0;
        end
        else
        begin
            if (cmd.load_text)
            begin
                belt_reg <= belt_ld;
                mill_reg <= mill_ld;
            end
            else if (cmd.round || (cmd.draw && round_due_reg))
            begin
                belt_reg <= belt_nx;
                mill_reg <= mill_nx;
            end
            if (cmd.draw)
            begin
                draw_reg      <= word_sel[30:16];
                round_due_reg <= !round_due_reg;
            end
        end
    end

endmodule

// ----- sv/rgr_result.sv -----
// Range scaling and output word register of the RadioGatun[32] generator.
// Multiplies span by draw, divides exactly by 32767, clamps. Uses rgr_pkg.
`timescale 1ns / 1ps

module rgr_result (
    input  logic             clk,
    input  logic             rst_n,
    input  rgr_pkg::rgr_cmd_t cmd,
    input  logic [15:0]      range_low,
    input  logic [15:0]      range_high,
    input  logic [15:0]      seed,
    input  logic [14:0]      draw15,
    output logic             range_bad,
    output logic             out_free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [15:0]      value,
    output logic             range_error
);
    import rgr_pkg::*;

    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic [31:0] prod_reg;
    logic [16:0] quot_reg;
    logic [15:0] value_reg;
    logic        error_reg;
    logic        out_valid_reg;

    logic [16:0] span;
    logic [17:0] r1;
    logic [2:0]  q1;
    logic [15:0] r2;
    logic        fix;
    logic [16:0] quot_next;
    logic [17:0] sum;
    logic [15:0] ranged;
    logic [15:0] value_next;

    assign range_bad   = (hi_reg < lo_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign range_error = error_reg;

    assign span = {1'b0, hi_reg} - {1'b0, lo_reg} + 17'd1;

    // p / 32767 by folding: p = q0*32767 + (q0 + low), twice, then one correction
    assign r1        = {3'b000, prod_reg[14:0]} + {1'b0, prod_reg[31:15]};
    assign q1        = r1[17:15];
    assign r2        = {1'b0, r1[14:0]} + {13'd0, q1};
    assign fix       = (r2 >= SCALE_DIV);
    assign quot_next = prod_reg[31:15] + {14'd0, q1} + {16'd0, fix};

    // offset and clamp to the high bound
    assign sum    = {1'b0, quot_reg} + {2'b00, lo_reg};
    assign ranged = (sum > {2'b00, hi_reg}) ? hi_reg : sum[15:0];

    always_comb
    begin
        case (cmd.sel)
            RES_SEED:  value_next = seed;
            RES_DRAW:  value_next = {1'b0, draw15};
            RES_RANGE: value_next = ranged;
            RES_ERROR: value_next = '0;
            default:   value_next = '0;
        endcase
    end

    // bounds, product and quotient
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lo_reg <= range_low;
            hi_reg <= range_high;
        end
        if (cmd.mul)
            prod_reg <= span * {17'd0, draw15};
        if (cmd.div)
            quot_reg <= quot_next;
        if (cmd.finish)
        begin
            value_reg <= value_next;
            error_reg <= (cmd.sel == RES_ERROR);
        end
    end

    // output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

endmodule

// ----- sv/radiogatun32_random_generator_unit.sv -----
// RadioGatun[32] generator top level: controller, belt/mill core, result unit.
// Plain draw: steps through the draw and finish states; range draw adds check, multiply, divide.
// Restart: digit steps (1..5 digits), text load, 17 blank rounds, 100 warm-up draw steps.
// One word in flight; the next is accepted the cycle after the result is loaded, and
// loading the result waits while the output word is stalled.
// Reset (rst_n, asynchronous, active low) clears belt, mill and seed, and sets round due.
`timescale 1ns / 1ps

module radiogatun32_random_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] value,
    output logic        range_error
);
    import rgr_pkg::*;

    rgr_cmd_t    cmd;
    rgr_stat_t   stat;
    logic [15:0] seed;
    logic [14:0] draw15;
    logic        digit_last;
    logic        range_bad;
    logic        out_free;

    assign stat.digit_last = digit_last;
    assign stat.range_bad  = range_bad;
    assign stat.out_free   = out_free;

    rgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    rgr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .seed           (seed),
        .draw15         (draw15),
        .digit_last     (digit_last)
    );

    rgr_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .range_low   (range_low),
        .range_high  (range_high),
        .seed        (seed),
        .draw15      (draw15),
        .range_bad   (range_bad),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .range_error (range_error)
    );

endmodule
